@@ sv/hrl_pkg.sv @@
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared types, angle constants and the CORDIC arctangent table for the
// heading rate limiter.
// ----------------------------------------------------------------------------
package hrl_pkg;

  // Q.12 and Q.16 angle constants
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;
  localparam int PI_Q16     = 205887;
  localparam int TABLE_LEN  = 24;
  localparam int MS_PER_S   = 1000;

  // Register indexes of the configuration port
  localparam logic REG_MAX_TURN_RATE = 1'b0;
  localparam logic REG_MIN_DISTANCE  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic sqx;       // len2 = x*x
    logic sqy;       // len2 += y*y
    logic sqm;       // compare against min_distance^2
    logic mdiv_ld;   // form R*ms
    logic div_step;  // one divider step
    logic m_take;    // capture step limit, R*ms / 1000 by reciprocal
    logic cinit;     // CORDIC pre-rotation
    logic cstep;     // one CORDIC iteration
    logic tgt;       // form target heading
    logic dec;       // rate-limit decision
    logic rdiv_ld;   // start |d|*1000 / ms
    logic r_take;    // capture saturated quotient rate
    logic commit;    // filter, update state, load output
  } hrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic cord_last;
    logic need_div;
    logic out_free;
  } hrl_sts_t;

  // atan(2^-i) in Q.16
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30385;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/hrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// hrl_ctrl
// Sequencer: steps the shared multiplier, the serial divider and the CORDIC
// of the datapath through one transaction.
// ----------------------------------------------------------------------------
module hrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hrl_pkg::hrl_sts_t sts,
  output hrl_pkg::hrl_cmd_t cmd
);
  import hrl_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_SQX    = 13'b0000000000010,
    ST_SQY    = 13'b0000000000100,
    ST_SQM    = 13'b0000000001000,
    ST_MDIV_S = 13'b0000000010000,
    ST_MDIV   = 13'b0000000100000,
    ST_CINIT  = 13'b0000001000000,
    ST_CORD   = 13'b0000010000000,
    ST_TGT    = 13'b0000100000000,
    ST_DEC    = 13'b0001000000000,
    ST_RDIV_S = 13'b0010000000000,
    ST_RDIV   = 13'b0100000000000,
    ST_FIN    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   rq_r, rq_nxt;  // quotient pending capture after rate division

  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    rq_nxt    = rq_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.sqx   = 1'b1;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        cmd.sqy   = 1'b1;
        state_nxt = ST_SQM;
      end
      ST_SQM: begin
        cmd.sqm   = 1'b1;
        state_nxt = ST_MDIV_S;
      end
      ST_MDIV_S: begin
        cmd.mdiv_ld = 1'b1;
        state_nxt   = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.m_take = 1'b1;
        state_nxt  = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.cinit  = 1'b1;
        state_nxt  = ST_CORD;
      end
      ST_CORD: begin
        cmd.cstep = 1'b1;
        if (sts.cord_last) state_nxt = ST_TGT;
      end
      ST_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        cmd.dec   = 1'b1;
        rq_nxt    = 1'b0;
        state_nxt = sts.need_div ? ST_RDIV_S : ST_FIN;
      end
      ST_RDIV_S: begin
        cmd.rdiv_ld = 1'b1;
        state_nxt   = ST_RDIV;
      end
      ST_RDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          rq_nxt    = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // capture quotient first, then wait for a free output register
        if (rq_r) begin
          cmd.r_take = 1'b1;
          rq_nxt     = 1'b0;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rq_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rq_r    <= rq_nxt;
    end
  end

endmodule

@@ sv/hrl_dp.sv @@
// ----------------------------------------------------------------------------
// hrl_dp
// Datapath: configuration registers, shared 17x17 multiplier, restoring
// divider, vectoring CORDIC, rate-limit decision, filter and output register.
// ----------------------------------------------------------------------------
module hrl_dp #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_heading,
  output logic signed [15:0] out_heading_rate,
  input  hrl_pkg::hrl_cmd_t  cmd,
  output hrl_pkg::hrl_sts_t  sts
);
  import hrl_pkg::*;

  localparam int ITERS = (CORDIC_ITERS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERS;
  localparam logic [4:0]  LAST_ITER = 5'(ITERS - 1);
  localparam logic signed [17:0] PI18  = 18'(PI_Q12);
  localparam logic signed [17:0] TPI18 = 18'(TWO_PI_Q12);
  // floor(n / 1000) = (n * M_RCP) >> 35, exact for n below 2^35 / 632
  localparam logic [25:0] M_RCP = 26'd34359739;
  // products at or above this give a step limit of 2*pi
  localparam logic [31:0] M_SAT = 32'(TWO_PI_Q12 * MS_PER_S);

  // configuration
  logic [14:0] max_rate_r;
  logic [15:0] min_dist_r;

  // captured transaction and state
  logic signed [15:0] x_r, y_r;
  logic [15:0]        ms_r;
  logic signed [15:0] prev_hdg_r, prev_rate_r;

  // length test
  logic [31:0] len2_r;
  logic        short_r;

  // divider
  logic [31:0] quo_r;
  logic [15:0] rem_r, dvs_r;
  logic [4:0]  dcnt_r;

  // CORDIC
  logic signed [26:0] cx_r, cy_r;
  logic signed [20:0] cz_r;
  logic [4:0]         ccnt_r;

  // decision
  logic [15:0]        m_r;
  logic signed [17:0] tgt_r, d_r, yaw_r;
  logic signed [16:0] rate_r;

  // output register
  logic               ov_r;
  logic signed [14:0] oh_r;
  logic signed [15:0] orate_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rate_r <= 15'(PI_Q12);
      min_dist_r <= 16'd26;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_TURN_RATE: max_rate_r <= cfg_wdata[14:0];
        REG_MIN_DISTANCE:  min_dist_r <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // shared multiplier operand select
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic [16:0]        d_abs;
  assign d_abs = d_r[17] ? 17'(-d_r) : 17'(d_r);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sqx) begin
      mul_a = {x_r[15], x_r};
      mul_b = {x_r[15], x_r};
    end else if (cmd.sqy) begin
      mul_a = {y_r[15], y_r};
      mul_b = {y_r[15], y_r};
    end else if (cmd.sqm) begin
      mul_a = {1'b0, min_dist_r};
      mul_b = {1'b0, min_dist_r};
    end else if (cmd.mdiv_ld) begin
      mul_a = {2'b0, max_rate_r};
      mul_b = {1'b0, ms_r};
    end else if (cmd.rdiv_ld) begin
      mul_a = d_abs;
      mul_b = 17'(MS_PER_S);
    end
  end
  assign mul_p = mul_a * mul_b;

  // step limit quotient by reciprocal multiplication
  logic [50:0] m_prod;
  logic [15:0] m_q;
  assign m_prod = quo_r[24:0] * M_RCP;
  assign m_q    = m_prod[50:35];

  // divider step
  logic [16:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_r, quo_r[31]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  // CORDIC step
  logic signed [26:0] xs, ys;
  logic signed [20:0] at;
  assign xs = cx_r >>> ccnt_r;
  assign ys = cy_r >>> ccnt_r;
  assign at = {4'b0, atan_q16(ccnt_r)};

  // CORDIC pre-rotation
  logic               xneg;
  logic signed [16:0] px, py;
  assign xneg = x_r[15];
  assign px   = xneg ? -{x_r[15], x_r} : {x_r[15], x_r};
  assign py   = xneg ? -{y_r[15], y_r} : {y_r[15], y_r};

  // round and clamp CORDIC angle
  logic signed [20:0] zr;
  logic signed [17:0] zc;
  assign zr = (cz_r + 21'sd8) >>> 4;
  always_comb begin
    if (zr > 21'(PI_Q12))        zc = PI18;
    else if (zr < -21'(PI_Q12))  zc = -PI18;
    else                         zc = zr[17:0];
  end

  // rate-limit decision
  logic signed [17:0] last, m18, dn, lm, lp, lm0, lp0, yaw_d;
  logic signed [16:0] rl, rate_d;
  logic               need_div;
  assign last = 18'(prev_hdg_r);
  assign m18  = {2'b0, m_r};
  assign rl   = {2'b0, max_rate_r};
  assign dn   = tgt_r - last;
  assign lm0  = last - m18;
  assign lp0  = last + m18;
  assign lm   = (lm0 < -PI18) ? lm0 + TPI18 : lm0;
  assign lp   = (lp0 > PI18) ? lp0 - TPI18 : lp0;
  always_comb begin
    need_div = 1'b0;
    rate_d   = '0;
    if (dn > PI18) begin
      yaw_d  = (dn - TPI18 < -m18) ? lm : tgt_r;
      rate_d = -rl;
    end else if (dn < -PI18) begin
      yaw_d  = (dn + TPI18 > m18) ? lp : tgt_r;
      rate_d = rl;
    end else if (dn < -m18) begin
      yaw_d  = lm;
      rate_d = -rl;
    end else if (dn > m18) begin
      yaw_d  = lp;
      rate_d = rl;
    end else begin
      yaw_d    = tgt_r;
      need_div = (ms_r != '0);
    end
  end

  // saturate quotient rate
  logic signed [16:0] rate_q;
  always_comb begin
    if (d_r[17]) rate_q = (quo_r > 32'd32768) ? -17'sd32768 : -17'(quo_r[16:0]);
    else         rate_q = (quo_r > 32'd32767) ? 17'sd32767 : 17'(quo_r[16:0]);
  end

  // filter
  logic signed [17:0] diff, hsum, yaw_f;
  logic signed [17:0] rsum, rate_f;
  assign diff   = (yaw_r > last) ? yaw_r - last : last - yaw_r;
  assign hsum   = last + yaw_r;
  assign yaw_f  = (diff <= m18) ? (hsum >>> 1) : yaw_r;
  assign rsum   = 18'(prev_rate_r) + 18'(rate_r);
  assign rate_f = rsum >>> 1;

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= in_dir_x;
      y_r  <= in_dir_y;
      ms_r <= in_elapsed_ms;
    end
    if (cmd.sqx) len2_r <= mul_p[31:0];
    if (cmd.sqy) len2_r <= len2_r + mul_p[31:0];
    if (cmd.sqm) short_r <= !(len2_r > mul_p[31:0]);
    // step limit product, then rate divider
    if (cmd.mdiv_ld) begin
      quo_r <= mul_p[31:0];
    end else if (cmd.rdiv_ld) begin
      quo_r  <= mul_p[31:0];
      rem_r  <= '0;
      dcnt_r <= '0;
      dvs_r  <= ms_r;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[30:0], ge};
      rem_r  <= ge ? 16'(rem_sh - {1'b0, dvs_r}) : rem_sh[15:0];
      dcnt_r <= dcnt_r + 5'd1;
    end
    if (cmd.m_take) m_r <= (quo_r >= M_SAT) ? 16'(TWO_PI_Q12) : m_q;
    // CORDIC
    if (cmd.cinit) begin
      cx_r   <= {{2{px[16]}}, px, 8'b0};
      cy_r   <= {{2{py[16]}}, py, 8'b0};
      cz_r   <= xneg ? (y_r[15] ? -21'(PI_Q16) : 21'(PI_Q16)) : '0;
      ccnt_r <= '0;
    end else if (cmd.cstep) begin
      if (!cy_r[26]) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
      ccnt_r <= ccnt_r + 5'd1;
    end
    if (cmd.tgt) tgt_r <= short_r ? last : zc;
    if (cmd.dec) begin
      d_r    <= dn;
      yaw_r  <= yaw_d;
      rate_r <= rate_d;
    end
    if (cmd.r_take) rate_r <= rate_q;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hdg_r  <= '0;
      prev_rate_r <= '0;
      ov_r        <= 1'b0;
    end else if (cmd.commit) begin
      prev_hdg_r  <= yaw_f[15:0];
      prev_rate_r <= rate_f[15:0];
      ov_r        <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      oh_r    <= yaw_f[14:0];
      orate_r <= rate_f[15:0];
    end
  end

  assign out_valid        = ov_r;
  assign out_heading      = oh_r;
  assign out_heading_rate = orate_r;

  assign sts.div_last  = (dcnt_r == 5'd31);
  assign sts.cord_last = (ccnt_r == LAST_ITER);
  assign sts.need_div  = need_div;
  assign sts.out_free  = !ov_r || !out_stall;

endmodule

@@ sv/heading_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// heading_rate_limiter
// Target heading by CORDIC atan2, rate-limited step with wrap at +/-pi, rate
// from step and elapsed time or the limit, both averaged with previous values.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------
//  input   | in_dir_x, in_dir_y, in_elapsed_ms      | in_valid/in_stall
//  result  | out_heading, out_heading_rate          | out_valid/out_stall
//  config  | cfg_index, cfg_wdata                   | cfg_we
//
//  The CORDIC runs CORDIC_ITERS iterations (capped at 24); when the rate comes
//  from the quotient, a 32-step serial division by the elapsed time forms it.
//  Reset (rst_n low, synchronous) clears heading and rate state, loads the
//  register defaults and empties the output register.
//  A result waits in the output register while out_stall is high; the next
//  transaction is accepted meanwhile and holds before its commit.
// ----------------------------------------------------------------------------
module heading_rate_limiter #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_heading,
  output logic signed [15:0] out_heading_rate
);
  import hrl_pkg::*;

  hrl_cmd_t cmd;
  hrl_sts_t sts;

  hrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrl_dp #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_elapsed_ms    (in_elapsed_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_heading      (out_heading),
    .out_heading_rate (out_heading_rate),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

@@ tb/sv/tb_heading_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// tb_heading_rate_limiter
// Self-checking testbench: drives direction vectors and elapsed times, keeps
// its own model of the heading filter state and compares every result.
// ----------------------------------------------------------------------------
module tb_heading_rate_limiter;
  import hrl_pkg::*;

  typedef struct {
    logic signed [14:0] heading;
    logic signed [15:0] heading_rate;
  } heading_t;

  localparam int EXP_DEPTH   = 64;
  localparam int HOLD_CYCLES = 600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_MAX_TURN_RATE;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_dir_x = '0;
  logic signed [15:0] in_dir_y = '0;
  logic [15:0]        in_elapsed_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] out_heading;
  logic signed [15:0] out_heading_rate;

  heading_rate_limiter DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state and configuration
  int unsigned turn_rate_lim;
  int unsigned min_dist;
  longint      last_heading;
  longint      last_rate;
  heading_t    exp_mem[EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_on = 1'b0;
  event        hold_go;

  function automatic longint asr_l(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cordic_heading(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    longint tbl[24];
    tbl = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q16 : -PI_Q16;
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < 16; i++) begin
      xs = asr_l(x, i);
      ys = asr_l(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += tbl[i];
      end else begin
        x -= ys; y += xs; z -= tbl[i];
      end
    end
    z = asr_l(z + 8, 4);
    if (z > PI_Q12) z = PI_Q12;
    if (z < -PI_Q12) z = -PI_Q12;
    return z;
  endfunction

  function automatic longint wrap_angle(longint a);
    if (a < -PI_Q12) a += TWO_PI_Q12;
    if (a > PI_Q12) a -= TWO_PI_Q12;
    return a;
  endfunction

  // Advance the model by one transaction and store the expected result
  function automatic void predict_heading(longint x, longint y, longint ms);
    longint target, m, d, yaw, rate, diff, mag;
    heading_t r;
    if (x * x + y * y > longint'(min_dist) * min_dist) target = cordic_heading(y, x);
    else target = last_heading;
    m = (longint'(turn_rate_lim) * ms) / 1000;
    if (m > TWO_PI_Q12) m = TWO_PI_Q12;
    d = target - last_heading;
    if (d > PI_Q12) begin
      yaw = (d - TWO_PI_Q12 < -m) ? wrap_angle(last_heading - m) : target;
      rate = -longint'(turn_rate_lim);
    end else if (d < -PI_Q12) begin
      yaw = (d + TWO_PI_Q12 > m) ? wrap_angle(last_heading + m) : target;
      rate = turn_rate_lim;
    end else if (d < -m) begin
      yaw = wrap_angle(last_heading - m);
      rate = -longint'(turn_rate_lim);
    end else if (d > m) begin
      yaw = wrap_angle(last_heading + m);
      rate = turn_rate_lim;
    end else begin
      yaw = target;
      if (ms == 0) rate = 0;
      else begin
        mag = ((d < 0) ? -d : d) * 1000 / ms;
        if (d < 0) rate = (mag > 32768) ? -32768 : -mag;
        else rate = (mag > 32767) ? 32767 : mag;
      end
    end
    diff = yaw - last_heading;
    if (diff < 0) diff = -diff;
    if (diff <= m) yaw = asr_l(last_heading + yaw, 1);
    rate = asr_l(last_rate + rate, 1);
    last_heading = yaw;
    last_rate = rate;
    r.heading = yaw[14:0];
    r.heading_rate = rate[15:0];
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  // Send one transaction with optional idle cycles in front
  task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_heading(x, y, ms);
  endtask

  // Wait for all results, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_TURN_RATE) turn_rate_lim = val[14:0];
    else min_dist = val;
  endtask

  // Long receiver hold-off, counted here once requested
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // Result check
  always @(posedge clk) begin
    heading_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result heading=%0d rate=%0d", out_heading, out_heading_rate);
        errors++;
      end else begin
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_heading !== e.heading) begin
          $error("heading expected %0d actual %0d", e.heading, out_heading);
          errors++;
        end
        if (out_heading_rate !== e.heading_rate) begin
          $error("heading_rate expected %0d actual %0d", e.heading_rate, out_heading_rate);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes;
    send_dir(16'sd0, 16'sd0, 16'd0);
    send_dir(16'sd32767, 16'sd0, 16'd100);
    send_dir(-16'sd32768, 16'sd0, 16'd100);
    send_dir(-16'sd32768, -16'sd1, 16'd65535);
    send_dir(16'sd0, 16'sd32767, 16'd65535);
    send_dir(16'sd0, -16'sd32768, 16'd1);
    send_dir(-16'sd32768, -16'sd32768, 16'd0);
    send_dir(16'sd32767, 16'sd32767, 16'd50);
    send_dir(16'sd26, 16'sd0, 16'd100);
    send_dir(16'sd27, 16'sd0, 16'd100);
    send_dir(-16'sd1000, 16'sd10, 16'd1000);
    send_dir(-16'sd1000, -16'sd10, 16'd1000);
    send_dir(16'sd500, 16'sd501, 16'd2);
    send_dir(16'sd500, -16'sd501, 16'd3000);
  endtask

  task automatic test_config_extremes;
    write_reg(REG_MAX_TURN_RATE, 16'd0);
    write_reg(REG_MIN_DISTANCE, 16'd0);
    send_dir(16'sd0, 16'sd0, 16'd100);
    send_dir(-16'sd100, 16'sd3, 16'd100);
    write_reg(REG_MAX_TURN_RATE, 16'hFFFF);
    write_reg(REG_MIN_DISTANCE, 16'hFFFF);
    send_dir(16'sd32767, 16'sd32767, 16'd65535);
    send_dir(-16'sd32768, 16'sd32767, 16'd10);
    write_reg(REG_MIN_DISTANCE, 16'd26);
    send_dir(-16'sd20000, 16'sd100, 16'd65535);
    send_dir(-16'sd20000, -16'sd100, 16'd65535);
  endtask

  task automatic random_items(int n);
    logic [15:0] ms;
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: ms = $urandom;
        1: ms = $urandom_range(0, 3);
        default: ms = $urandom_range(10, 200);
      endcase
      x = $urandom;
      y = $urandom;
      if ($urandom_range(9) == 0) begin
        x = $signed(16'($urandom_range(0, 40))) - 16'sd20;
        y = $signed(16'($urandom_range(0, 40))) - 16'sd20;
      end
      send_dir(x, y, ms);
    end
  endtask

  task automatic test_random_phase(int s, int r, int n);
    send_idle_pct = s;
    recv_idle_pct = r;
    write_reg(REG_MAX_TURN_RATE, 16'($urandom_range(0, 32767)));
    write_reg(REG_MIN_DISTANCE, 16'($urandom_range(0, 300)));
    random_items(n);
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_go;
    random_items(12);
    drain();
    random_items(5);
  endtask

  initial begin
    turn_rate_lim = 12868;
    min_dist = 26;
    last_heading = 0;
    last_rate = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_config_extremes();
    test_random_phase(36, 63, 400);
    test_random_phase(63, 36, 400);
    test_random_phase(0, 0, 400);
    test_backpressure();
    drain();
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("** heading_rate_limiter: PASSED **");
    end else begin
      $display("** heading_rate_limiter: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("** heading_rate_limiter: FAILED **");
    $finish;
  end
endmodule
